>>> src/ddg_pkg.sv
// Shared types and codes for the disk DMA glue register block.
// No dependencies.
package ddg_pkg;

   typedef enum logic [1:0] {
      MODE_BUS_READ  = 2'd0,
      MODE_BUS_WRITE = 2'd1,
      MODE_DRQ       = 2'd2,
      MODE_INTRQ     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CTRL_NONE  = 2'd0,
      CTRL_READ  = 2'd1,
      CTRL_WRITE = 2'd2
   } ctrl_op_type;

   typedef enum logic [1:0] {
      DMA_NONE      = 2'd0,
      DMA_MEM_WRITE = 2'd1,
      DMA_MEM_READ  = 2'd2
   } dma_op_type;

   // card register offsets
   localparam logic [3:0] OFF_PTR_LO  = 4'h8;
   localparam logic [3:0] OFF_PTR_HI  = 4'h9;
   localparam logic [3:0] OFF_RD_EN   = 4'hA;
   localparam logic [3:0] OFF_WR_EN   = 4'hB;
   localparam logic [3:0] OFF_DMA_OFF = 4'hC;
   localparam logic [3:0] OFF_SELECT  = 4'hD;
   localparam logic [3:0] OFF_STATUS  = 4'hF;

   // controller data register, used by DMA transfers
   localparam logic [1:0] CTRL_DATA_REG = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] offset;
      logic [7:0] data;
      logic       debug_peek;
      logic       line_level;
      logic [7:0] ctrl_read_data;
      logic [7:0] mem_read_data;
      logic       drive_two_sided;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [1:0]  ctrl_op;
      logic [1:0]  ctrl_reg;
      logic [7:0]  ctrl_write_data;
      logic [1:0]  dma_op;
      logic [15:0] dma_address;
      logic [7:0]  dma_write_data;
      logic        select_update;
      logic [2:0]  drive_selected;
      logic        density_out;
      logic        side_out;
   } rsp_type;

endpackage

>>> src/disk_dma_glue_registers_unit.sv
// Top level of the disk DMA glue register block: decode, DMA pointer and latches.
// Depends on ddg_pkg.
//
// Bus glue of a floppy controller card. Each request transfer is one bus read,
// bus write, DRQ line event or INTRQ line event against the card's 16-byte
// register space; each produces exactly one response transfer. Offsets 0-7 map
// to controller register (offset mod 4), 8/9 load the DMA pointer bytes, A/B set
// the read/write DMA enables, C clears both, D latches density, side and drive
// select, F returns status (bit 7 any DMA enable, bit 6 two-sided latch). A DRQ
// at level 1 moves one byte (read DMA wins if both enables are on) and bumps the
// pointer, wrapping at 16 bits; INTRQ drops both enables. Timing: a request is
// captured in an input register, decoded by combinational logic and lands in the
// response register, and one transfer is taken every cycle while the response
// side keeps up. The response register is the only thing that can hold a request
// back: req_stall rises only when both the input and response registers are full
// and rsp_stall is high.
module disk_dma_glue_registers_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_offset,
   input  logic [7:0]  req_data,
   input  logic        req_debug_peek,
   input  logic        req_line_level,
   input  logic [7:0]  req_ctrl_read_data,
   input  logic [7:0]  req_mem_read_data,
   input  logic        req_drive_two_sided,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_ctrl_op,
   output logic [1:0]  rsp_ctrl_reg,
   output logic [7:0]  rsp_ctrl_write_data,
   output logic [1:0]  rsp_dma_op,
   output logic [15:0] rsp_dma_address,
   output logic [7:0]  rsp_dma_write_data,
   output logic        rsp_select_update,
   output logic [2:0]  rsp_drive_selected,
   output logic        rsp_density_out,
   output logic        rsp_side_out
);

   // pipeline registers
   logic              in_valid_ff;
   ddg_pkg::req_type  in_ff;
   logic              out_valid_ff;
   ddg_pkg::rsp_type  out_ff;

   // architectural state
   logic [15:0] ptr_ff, ptr_in;
   logic        rd_en_ff, rd_en_in;
   logic        wr_en_ff, wr_en_in;
   logic        density_ff, density_in;
   logic        side_ff, side_in;
   logic        two_sided_ff, two_sided_in;

   ddg_pkg::rsp_type rsp_in;

   logic out_free;
   logic advance;

   // response slot frees up when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Decode of the captured request against current state. State updates
   // commit only when the item moves into the response register.
   always_comb begin
      ptr_in       = ptr_ff;
      rd_en_in     = rd_en_ff;
      wr_en_in     = wr_en_ff;
      density_in   = density_ff;
      side_in      = side_ff;
      two_sided_in = two_sided_ff;
      rsp_in       = '0;

      unique case (ddg_pkg::mode_type'(in_ff.mode))
         ddg_pkg::MODE_BUS_READ: begin
            if (!in_ff.offset[3]) begin
               rsp_in.ctrl_op   = ddg_pkg::CTRL_READ;
               rsp_in.ctrl_reg  = in_ff.offset[1:0];
               rsp_in.read_data = in_ff.ctrl_read_data;
            end else begin
               unique case (in_ff.offset)
                  ddg_pkg::OFF_RD_EN:   if (!in_ff.debug_peek) rd_en_in = 1'b1;
                  ddg_pkg::OFF_WR_EN:   if (!in_ff.debug_peek) wr_en_in = 1'b1;
                  ddg_pkg::OFF_DMA_OFF: begin
                     if (!in_ff.debug_peek) begin
                        rd_en_in = 1'b0;
                        wr_en_in = 1'b0;
                     end
                  end
                  ddg_pkg::OFF_STATUS:
                     rsp_in.read_data = {rd_en_ff | wr_en_ff, two_sided_ff, 6'b0};
                  default: ;
               endcase
            end
         end
         ddg_pkg::MODE_BUS_WRITE: begin
            if (!in_ff.offset[3]) begin
               rsp_in.ctrl_op         = ddg_pkg::CTRL_WRITE;
               rsp_in.ctrl_reg        = in_ff.offset[1:0];
               rsp_in.ctrl_write_data = in_ff.data;
            end else begin
               unique case (in_ff.offset)
                  ddg_pkg::OFF_PTR_LO:  ptr_in = {ptr_ff[15:8], in_ff.data};
                  ddg_pkg::OFF_PTR_HI:  ptr_in = {in_ff.data, ptr_ff[7:0]};
                  ddg_pkg::OFF_RD_EN:   rd_en_in = 1'b1;
                  ddg_pkg::OFF_WR_EN:   wr_en_in = 1'b1;
                  ddg_pkg::OFF_DMA_OFF: begin
                     rd_en_in = 1'b0;
                     wr_en_in = 1'b0;
                  end
                  ddg_pkg::OFF_SELECT: begin
                     density_in           = in_ff.data[7];
                     side_in              = in_ff.data[6];
                     rsp_in.select_update = 1'b1;
                     // highest set select bit wins
                     if (in_ff.data[3])      rsp_in.drive_selected = 3'd4;
                     else if (in_ff.data[2]) rsp_in.drive_selected = 3'd3;
                     else if (in_ff.data[1]) rsp_in.drive_selected = 3'd2;
                     else if (in_ff.data[0]) rsp_in.drive_selected = 3'd1;
                     if (in_ff.data[3:0] != 4'd0) two_sided_in = in_ff.drive_two_sided;
                  end
                  default: ;
               endcase
            end
         end
         ddg_pkg::MODE_DRQ: begin
            if (in_ff.line_level && (rd_en_ff || wr_en_ff)) begin
               rsp_in.ctrl_reg    = ddg_pkg::CTRL_DATA_REG;
               rsp_in.dma_address = ptr_ff;
               ptr_in             = ptr_ff + 16'd1;
               if (rd_en_ff) begin
                  // controller to memory
                  rsp_in.ctrl_op        = ddg_pkg::CTRL_READ;
                  rsp_in.dma_op         = ddg_pkg::DMA_MEM_WRITE;
                  rsp_in.dma_write_data = in_ff.ctrl_read_data;
               end else begin
                  // memory to controller
                  rsp_in.ctrl_op         = ddg_pkg::CTRL_WRITE;
                  rsp_in.dma_op          = ddg_pkg::DMA_MEM_READ;
                  rsp_in.ctrl_write_data = in_ff.mem_read_data;
               end
            end
         end
         default: begin
            // INTRQ: end of command drops both enables
            rd_en_in = 1'b0;
            wr_en_in = 1'b0;
         end
      endcase

      rsp_in.density_out = density_in;
      rsp_in.side_out    = side_in;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         rd_en_ff     <= 1'b0;
         wr_en_ff     <= 1'b0;
         density_ff   <= 1'b0;
         side_ff      <= 1'b0;
         two_sided_ff <= 1'b0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (out_free) out_valid_ff <= in_valid_ff;
         if (advance) begin
            ptr_ff       <= ptr_in;
            rd_en_ff     <= rd_en_in;
            wr_en_ff     <= wr_en_in;
            density_ff   <= density_in;
            side_ff      <= side_in;
            two_sided_ff <= two_sided_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff.mode            <= req_mode;
         in_ff.offset          <= req_offset;
         in_ff.data            <= req_data;
         in_ff.debug_peek      <= req_debug_peek;
         in_ff.line_level      <= req_line_level;
         in_ff.ctrl_read_data  <= req_ctrl_read_data;
         in_ff.mem_read_data   <= req_mem_read_data;
         in_ff.drive_two_sided <= req_drive_two_sided;
      end
      if (advance) out_ff <= rsp_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = out_ff.read_data;
   assign rsp_ctrl_op         = out_ff.ctrl_op;
   assign rsp_ctrl_reg        = out_ff.ctrl_reg;
   assign rsp_ctrl_write_data = out_ff.ctrl_write_data;
   assign rsp_dma_op          = out_ff.dma_op;
   assign rsp_dma_address     = out_ff.dma_address;
   assign rsp_dma_write_data  = out_ff.dma_write_data;
   assign rsp_select_update   = out_ff.select_update;
   assign rsp_drive_selected  = out_ff.drive_selected;
   assign rsp_density_out     = out_ff.density_out;
   assign rsp_side_out        = out_ff.side_out;

`ifndef SYNTH
   // a DMA cycle always pairs with a data-register access
   a_dma_pairs_ctrl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dma_op != ddg_pkg::DMA_NONE) |->
      (rsp_ctrl_op != ddg_pkg::CTRL_NONE && rsp_ctrl_reg == ddg_pkg::CTRL_DATA_REG))
      else $error("dma cycle without data register access");

   a_no_dma_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dma_op == ddg_pkg::DMA_NONE) |-> (rsp_dma_address == 16'd0))
      else $error("dma address set without dma cycle");

   a_drive_needs_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_select_update) |-> (rsp_drive_selected == 3'd0))
      else $error("drive select without select write");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in pipeline");

   a_pointer_step: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.mode == ddg_pkg::MODE_DRQ && rsp_in.dma_op != ddg_pkg::DMA_NONE)
      |=> (ptr_ff == $past(ptr_ff) + 16'd1))
      else $error("dma pointer did not advance");
`endif

endmodule

>>> test/disk_dma_glue_registers_unit_tb.sv
// Self-checking testbench for disk_dma_glue_registers_unit: directed and random
// bus, DRQ and INTRQ transfers checked against an in-bench model of the card.
// Depends on ddg_pkg and the unit under test.
module disk_dma_glue_registers_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // offsets with no name in the package
   localparam logic [3:0] OFF_CTRL_FIRST  = 4'h0;
   localparam logic [3:0] OFF_CTRL_SECTOR = 4'h2;
   localparam logic [3:0] OFF_CTRL_TRACK  = 4'h5;
   localparam logic [3:0] OFF_CTRL_LAST   = 4'h7;
   localparam logic [3:0] OFF_SPARE       = 4'hE;

   // status byte layout
   localparam int STAT_DMA_BIT       = 7;
   localparam int STAT_TWO_SIDED_BIT = 6;

   localparam int ITEMS_PER_PHASE = 240;
   localparam int MAX_REPORTS     = 10;
   localparam int SETTLE_CYCLES   = 10;
   // watchdog bound, far above what the slowest run needs
   localparam int CYCLE_LIMIT     = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [3:0]  req_offset = '0;
   logic [7:0]  req_data = '0;
   logic        req_debug_peek = 1'b0;
   logic        req_line_level = 1'b0;
   logic [7:0]  req_ctrl_read_data = '0;
   logic [7:0]  req_mem_read_data = '0;
   logic        req_drive_two_sided = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_ctrl_op;
   logic [1:0]  rsp_ctrl_reg;
   logic [7:0]  rsp_ctrl_write_data;
   logic [1:0]  rsp_dma_op;
   logic [15:0] rsp_dma_address;
   logic [7:0]  rsp_dma_write_data;
   logic        rsp_select_update;
   logic [2:0]  rsp_drive_selected;
   logic        rsp_density_out;
   logic        rsp_side_out;

   disk_dma_glue_registers_unit uut (.*);

   // Stimulus and scoreboard state
   ddg_pkg::req_type bus_items[$];         // transfers waiting to be driven
   ddg_pkg::req_type item_on_bus;          // transfer currently presented on req_*
   ddg_pkg::rsp_type card_responses[$];    // predicted responses, oldest first

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int mismatches      = 0;
   int cycle_count     = 0;

   // Card model state: DMA pointer, enables and drive select latches
   logic [15:0] dma_ptr;
   logic        rd_dma_on;
   logic        wr_dma_on;
   logic        density_q;
   logic        side_q;
   logic        two_sided_q;

   initial begin
      forever #10 clock = ~clock;
   end

   // Apply one transfer to the card model and return the response it produces.
   function automatic ddg_pkg::rsp_type card_step(input ddg_pkg::req_type r);
      ddg_pkg::rsp_type o;
      logic [2:0] drive;
      o = '0;
      drive = 3'd0;
      unique case (ddg_pkg::mode_type'(r.mode))
         ddg_pkg::MODE_BUS_READ: begin
            if (r.offset <= OFF_CTRL_LAST) begin
               o.ctrl_op = ddg_pkg::CTRL_READ;
               o.ctrl_reg = r.offset[1:0];
               o.read_data = r.ctrl_read_data;
            end else begin
               // peek reads of the enable offsets must leave the enables alone
               unique case (r.offset)
                  ddg_pkg::OFF_RD_EN:   if (!r.debug_peek) rd_dma_on = 1'b1;
                  ddg_pkg::OFF_WR_EN:   if (!r.debug_peek) wr_dma_on = 1'b1;
                  ddg_pkg::OFF_DMA_OFF: if (!r.debug_peek) begin
                     rd_dma_on = 1'b0;
                     wr_dma_on = 1'b0;
                  end
                  ddg_pkg::OFF_STATUS: begin
                     o.read_data[STAT_DMA_BIT] = rd_dma_on | wr_dma_on;
                     o.read_data[STAT_TWO_SIDED_BIT] = two_sided_q;
                  end
                  default: ;
               endcase
            end
         end
         ddg_pkg::MODE_BUS_WRITE: begin
            if (r.offset <= OFF_CTRL_LAST) begin
               o.ctrl_op = ddg_pkg::CTRL_WRITE;
               o.ctrl_reg = r.offset[1:0];
               o.ctrl_write_data = r.data;
            end else begin
               unique case (r.offset)
                  ddg_pkg::OFF_PTR_LO:  dma_ptr[7:0] = r.data;
                  ddg_pkg::OFF_PTR_HI:  dma_ptr[15:8] = r.data;
                  ddg_pkg::OFF_RD_EN:   rd_dma_on = 1'b1;
                  ddg_pkg::OFF_WR_EN:   wr_dma_on = 1'b1;
                  ddg_pkg::OFF_DMA_OFF: begin
                     rd_dma_on = 1'b0;
                     wr_dma_on = 1'b0;
                  end
                  ddg_pkg::OFF_SELECT: begin
                     density_q = r.data[7];
                     side_q = r.data[6];
                     // highest set select bit wins
                     if (r.data[3]) drive = 3'd4;
                     else if (r.data[2]) drive = 3'd3;
                     else if (r.data[1]) drive = 3'd2;
                     else if (r.data[0]) drive = 3'd1;
                     if (drive != 3'd0) two_sided_q = r.drive_two_sided;
                     o.select_update = 1'b1;
                     o.drive_selected = drive;
                  end
                  default: ;
               endcase
            end
         end
         ddg_pkg::MODE_DRQ: begin
            // read DMA (controller to memory) wins when both are on
            if (r.line_level && rd_dma_on) begin
               o.ctrl_op = ddg_pkg::CTRL_READ;
               o.ctrl_reg = ddg_pkg::CTRL_DATA_REG;
               o.dma_op = ddg_pkg::DMA_MEM_WRITE;
               o.dma_address = dma_ptr;
               o.dma_write_data = r.ctrl_read_data;
               dma_ptr = dma_ptr + 16'd1;
            end else if (r.line_level && wr_dma_on) begin
               o.ctrl_op = ddg_pkg::CTRL_WRITE;
               o.ctrl_reg = ddg_pkg::CTRL_DATA_REG;
               o.ctrl_write_data = r.mem_read_data;
               o.dma_op = ddg_pkg::DMA_MEM_READ;
               o.dma_address = dma_ptr;
               dma_ptr = dma_ptr + 16'd1;
            end
         end
         default: begin
            // INTRQ drops both enables at either level
            rd_dma_on = 1'b0;
            wr_dma_on = 1'b0;
         end
      endcase
      o.density_out = density_q;
      o.side_out = side_q;
      return o;
   endfunction

   // Queue one transfer; fields not given are random.
   task automatic add_item(input ddg_pkg::mode_type m, input logic [3:0] off,
                           input logic [7:0] d, input logic peek, input logic lvl);
      ddg_pkg::req_type r;
      r.mode = m;
      r.offset = off;
      r.data = d;
      r.debug_peek = peek;
      r.line_level = lvl;
      r.ctrl_read_data = 8'($urandom_range(255));
      r.mem_read_data = 8'($urandom_range(255));
      r.drive_two_sided = 1'($urandom_range(1));
      bus_items.push_back(r);
   endtask

   task automatic add_random(input ddg_pkg::mode_type m, input logic [3:0] off);
      add_item(m, off, 8'($urandom_range(255)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
   endtask

   // Queue one random sequence; most are well-formed DMA and select traffic.
   task automatic add_sequence();
      int pick;
      int burst;
      logic [3:0] en;
      pick = $urandom_range(99);
      if (pick < 15) begin
         // pointer load, often close to the 16-bit wrap
         add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_PTR_LO,
                  ($urandom_range(1) != 0) ? 8'($urandom_range(255, 248))
                                           : 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
         add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_PTR_HI,
                  ($urandom_range(1) != 0) ? 8'hFF : 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 45) begin
         // enable one or both DMA directions, run a burst, then in most runs shut it off
         burst = $urandom_range(8, 2);
         en = ($urandom_range(1) != 0) ? ddg_pkg::OFF_RD_EN : ddg_pkg::OFF_WR_EN;
         add_item(ddg_pkg::mode_type'($urandom_range(1)), en, 8'($urandom_range(255)),
                  1'b0, 1'($urandom_range(1)));
         if ($urandom_range(3) == 0)
            add_random(ddg_pkg::MODE_BUS_WRITE,
                       ddg_pkg::OFF_RD_EN + ddg_pkg::OFF_WR_EN - en);
         repeat (burst) begin
            if ($urandom_range(9) == 0) add_random(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_STATUS);
            add_item(ddg_pkg::MODE_DRQ, 4'($urandom_range(15)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), ($urandom_range(7) != 0));
         end
         case ($urandom_range(3))
            0: add_random(ddg_pkg::MODE_INTRQ, 4'($urandom_range(15)));
            1: add_random(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_DMA_OFF);
            2: add_random(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_DMA_OFF);
            default: ;
         endcase
      end else if (pick < 60) begin
         add_random(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_SELECT);
         add_random(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_STATUS);
      end else if (pick < 75) begin
         add_random(ddg_pkg::mode_type'($urandom_range(1)),
                    4'($urandom_range(OFF_CTRL_LAST, OFF_CTRL_FIRST)));
      end else if (pick < 85) begin
         // peek reads of the enable offsets followed by a DRQ
         add_item(ddg_pkg::MODE_BUS_READ,
                  4'($urandom_range(ddg_pkg::OFF_DMA_OFF, ddg_pkg::OFF_RD_EN)),
                  8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
         add_item(ddg_pkg::MODE_DRQ, 4'($urandom_range(15)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b1);
      end else begin
         add_random(ddg_pkg::mode_type'($urandom_range(3)), 4'($urandom_range(15)));
      end
   endtask

   // Hold the sender off until every predicted response has come back.
   // Sampled at the falling edge so the driver and monitor updates have settled.
   task automatic wait_drained();
      while (bus_items.size() != 0 || req_valid || card_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // Driver: present queued transfers, holding each until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         dma_ptr = '0;
         rd_dma_on = 1'b0;
         wr_dma_on = 1'b0;
         density_q = 1'b0;
         side_q = 1'b0;
         two_sided_q = 1'b0;
      end else begin
         if (req_valid && !req_stall)
            card_responses.push_back(card_step(item_on_bus));
         // free to load: nothing presented, or the presented one just went
         if (!req_valid || !req_stall) begin
            if (bus_items.size() == 0 || $urandom_range(99) < sender_idle_pct) begin
               req_valid <= 1'b0;
            end else begin
               item_on_bus = bus_items.pop_front();
               req_valid <= 1'b1;
               req_mode <= item_on_bus.mode;
               req_offset <= item_on_bus.offset;
               req_data <= item_on_bus.data;
               req_debug_peek <= item_on_bus.debug_peek;
               req_line_level <= item_on_bus.line_level;
               req_ctrl_read_data <= item_on_bus.ctrl_read_data;
               req_mem_read_data <= item_on_bus.mem_read_data;
               req_drive_two_sided <= item_on_bus.drive_two_sided;
            end
         end
      end
   end

   // Monitor: random backpressure and in-order check of every response transfer.
   always @(posedge clock) begin
      ddg_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (card_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("response transfer with none expected");
            end else begin
               want = card_responses.pop_front();
               compare_field("read_data", 16'(want.read_data), 16'(rsp_read_data));
               compare_field("ctrl_op", 16'(want.ctrl_op), 16'(rsp_ctrl_op));
               compare_field("ctrl_reg", 16'(want.ctrl_reg), 16'(rsp_ctrl_reg));
               compare_field("ctrl_write_data", 16'(want.ctrl_write_data),
                             16'(rsp_ctrl_write_data));
               compare_field("dma_op", 16'(want.dma_op), 16'(rsp_dma_op));
               compare_field("dma_address", want.dma_address, rsp_dma_address);
               compare_field("dma_write_data", 16'(want.dma_write_data),
                             16'(rsp_dma_write_data));
               compare_field("select_update", 16'(want.select_update),
                             16'(rsp_select_update));
               compare_field("drive_selected", 16'(want.drive_selected),
                             16'(rsp_drive_selected));
               compare_field("density_out", 16'(want.density_out), 16'(rsp_density_out));
               compare_field("side_out", 16'(want.side_out), 16'(rsp_side_out));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int sender_pct[5];
      int stall_pct[5];
      int target;
      sender_pct = '{0, 78, 0, 13, 0};
      stall_pct  = '{0, 0, 78, 13, 0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: status after reset, controller pass-through at both ends
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_STATUS, 8'h00, 1'b0, 1'b0);
      bus_items[$].drive_two_sided = 1'b1;
      add_item(ddg_pkg::MODE_BUS_READ, OFF_CTRL_FIRST, 8'hFF, 1'b0, 1'b1);
      bus_items[$].ctrl_read_data = 8'hFF;
      add_item(ddg_pkg::MODE_BUS_READ, OFF_CTRL_LAST, 8'h00, 1'b1, 1'b0);
      bus_items[$].ctrl_read_data = 8'h00;
      add_item(ddg_pkg::MODE_BUS_WRITE, OFF_CTRL_SECTOR, 8'hFF, 1'b1, 1'b1);
      add_item(ddg_pkg::MODE_BUS_WRITE, OFF_CTRL_TRACK, 8'h00, 1'b0, 1'b0);
      // pointer to the top so the first DMA transfer wraps it
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_PTR_LO, 8'hFF, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_PTR_HI, 8'hFF, 1'b1, 1'b0);
      // peek: no effect
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_RD_EN, 8'h00, 1'b1, 1'b0);
      // peek ignored on writes
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_RD_EN, 8'h00, 1'b1, 1'b0);
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_WR_EN, 8'h00, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_STATUS, 8'h00, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_DRQ, OFF_CTRL_FIRST, 8'h00, 1'b0, 1'b1);     // both on: read wins
      add_item(ddg_pkg::MODE_DRQ, OFF_CTRL_FIRST, 8'h00, 1'b0, 1'b0);     // low level: nothing
      add_item(ddg_pkg::MODE_INTRQ, OFF_CTRL_FIRST, 8'h00, 1'b1, 1'b0);   // clears at low too
      add_item(ddg_pkg::MODE_DRQ, OFF_CTRL_FIRST, 8'h00, 1'b0, 1'b1);     // no enable: nothing
      // read acts as write
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_WR_EN, 8'h00, 1'b0, 1'b0);
      // peek: stays on
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_DMA_OFF, 8'h00, 1'b1, 1'b0);
      add_item(ddg_pkg::MODE_DRQ, OFF_CTRL_FIRST, 8'h00, 1'b0, 1'b1);
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_DMA_OFF, 8'h00, 1'b0, 1'b0);
      // unmapped reads and ignored writes
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_PTR_LO, 8'h00, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_SELECT, 8'h00, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_BUS_READ, OFF_SPARE, 8'h00, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_STATUS, 8'hFF, 1'b0, 1'b0);
      // drive select: none set keeps two-sided latch, then highest bit wins
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_SELECT, 8'h00, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_SELECT, 8'hFF, 1'b0, 1'b0);
      bus_items[$].drive_two_sided = 1'b1;
      add_item(ddg_pkg::MODE_BUS_READ, ddg_pkg::OFF_STATUS, 8'h00, 1'b0, 1'b0);
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_SELECT, 8'h46, 1'b0, 1'b0);
      bus_items[$].drive_two_sided = 1'b0;
      add_item(ddg_pkg::MODE_BUS_WRITE, ddg_pkg::OFF_SELECT, 8'h81, 1'b0, 1'b0);
      wait_drained();

      // Random phases; each ends with the sender held off until all responses are in
      for (int p = 0; p < 5; p++) begin
         sender_idle_pct = sender_pct[p];
         rsp_stall_pct = stall_pct[p];
         target = bus_items.size() + ITEMS_PER_PHASE;
         while (bus_items.size() < target) add_sequence();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
